FILE: hw/rtl/fpsa_pkg.sv
// shared constants and types for the four-point stencil average block
`default_nettype none

package fpsa_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int DATA_W = 32;
  localparam int PART_W = DATA_W + 1;
  localparam int SUM_W  = DATA_W + 2;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CNT_W = ROW_W + 1;

  localparam int GW_W = 11;
  localparam int GH_W = 13;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_col;
    logic             wr_en;
    logic [COL_W-1:0] wr_col;
  } lb_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fpsa_lines.sv
// two line buffers with read-modify-write forwarding between back-to-back columns
`default_nettype none

module fpsa_lines (
  input  logic                         clk,
  input  logic                         rst,
  input  fpsa_pkg::lb_ctl_t            ctl,
  input  logic [fpsa_pkg::DATA_W-1:0]  wr_cur,
  output logic [fpsa_pkg::DATA_W-1:0]  old_c,
  output logic [fpsa_pkg::DATA_W-1:0]  mid_c,
  output logic [fpsa_pkg::DATA_W-1:0]  mid_n
);
  import fpsa_pkg::*;

  logic [DATA_W-1:0] older_mem  [MAX_WIDTH];
  logic [DATA_W-1:0] middle_mem [MAX_WIDTH];

  logic [DATA_W-1:0] old_rd;
  logic [DATA_W-1:0] mc_rd;
  logic [DATA_W-1:0] mn_rd;
  logic [COL_W-1:0]  rd_col_n;

  logic              fwd_old;
  logic              fwd_mc;
  logic              fwd_mn;
  logic [DATA_W-1:0] fwd_old_data;
  logic [DATA_W-1:0] fwd_mid_data;

  assign rd_col_n = ctl.rd_col + COL_W'(1);

  // older row takes the middle entry, middle row takes the new sample
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      older_mem[ctl.wr_col]  <= mid_c;
      middle_mem[ctl.wr_col] <= wr_cur;
    end
    if (ctl.rd_en) begin
      old_rd <= older_mem[ctl.rd_col];
      mc_rd  <= middle_mem[ctl.rd_col];
      mn_rd  <= middle_mem[rd_col_n];
    end
  end

  // a read that lands on the entry being written this edge gets the write data forwarded
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_old <= 1'b0;
      fwd_mc  <= 1'b0;
      fwd_mn  <= 1'b0;
    end else if (ctl.rd_en) begin
      fwd_old <= ctl.wr_en && (ctl.wr_col == ctl.rd_col);
      fwd_mc  <= ctl.wr_en && (ctl.wr_col == ctl.rd_col);
      fwd_mn  <= ctl.wr_en && (ctl.wr_col == rd_col_n);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      fwd_old_data <= mid_c;
      fwd_mid_data <= wr_cur;
    end
  end

  assign old_c = fwd_old ? fwd_old_data : old_rd;
  assign mid_c = fwd_mc  ? fwd_mid_data : mc_rd;
  assign mid_n = fwd_mn  ? fwd_mid_data : mn_rd;

endmodule

`default_nettype wire

FILE: hw/rtl/four_point_stencil_average.sv
// Four-point stencil average over a raster grid of signed 32-bit samples.
// Item channel (item_valid/item_ready): mode 0 carries a grid sample in raster
// order, mode 1 is a drain tick; after the last sample of a frame send
// grid_width drain ticks to flush the last row. A beat that does not fit the
// current phase (a tick outside the drain, a sample during it) is taken and
// dropped. The sample at (r,c) yields the result for cell (r-1,c); row 0
// yields nothing until row 1 arrives.
// Result channel (result_valid/result_ready): avg_value = (up+left+right+down)/4
// truncated toward zero, with out_row, out_col and frame_last on the last cell.
// A beat passes the column stage, pair sums, full sum and output registers.
// Throughput is one beat per cycle while results are not stalled: each column
// does one older-line and two middle-line reads, written back with forwarding.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 grid_width,
// index 1 grid_height; write only while the block is idle.
// Reset clears counters, drain state and all pipeline valids and restores
// width 1024, height 4096; line buffers need no clearing. When the receiver
// stalls, results fill the four stages and then item_ready drops.
`default_nettype none

module four_point_stencil_average (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic                                 mode,
  input  logic signed [fpsa_pkg::DATA_W-1:0]   sample,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [fpsa_pkg::DATA_W-1:0]   avg_value,
  output logic [fpsa_pkg::ROW_W-1:0]           out_row,
  output logic [fpsa_pkg::COL_W-1:0]           out_col,
  output logic                                 frame_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpsa_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fpsa_pkg::*;

  logic [GW_W-1:0]   grid_width;
  logic [GH_W-1:0]   grid_height;
  logic [GW_W-1:0]   w_eff;
  logic [GH_W-1:0]   h_eff;

  logic [COL_W-1:0]  col_count;
  logic [CNT_W-1:0]  row_count;
  logic              draining;

  logic              item_fire;
  logic              go;
  logic [GW_W-1:0]   col_inc;
  logic              last_col;
  logic [CNT_W:0]    row_inc;
  logic              frame_end;
  logic [DATA_W-1:0] cur;

  // column stage: line buffer data is valid here
  logic              s1_v;
  logic              s1_res;
  logic [DATA_W-1:0] s1_cur;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic              s1_up;
  logic              s1_left;
  logic              s1_right;
  logic              s1_last;
  logic              s1_commit;
  logic [DATA_W-1:0] left_q;

  logic [DATA_W-1:0] old_c;
  logic [DATA_W-1:0] mid_c;
  logic [DATA_W-1:0] mid_n;
  lb_ctl_t           lb_ctl;

  logic [DATA_W-1:0] up_m;
  logic [DATA_W-1:0] left_m;
  logic [DATA_W-1:0] right_m;

  logic              s2_v;
  logic              s2_free;
  logic [PART_W-1:0] s2_a;
  logic [PART_W-1:0] s2_b;
  logic [ROW_W-1:0]  s2_row;
  logic [COL_W-1:0]  s2_col;
  logic              s2_last;

  logic              s3_v;
  logic              s3_free;
  logic [SUM_W-1:0]  s3_sum;
  logic [ROW_W-1:0]  s3_row;
  logic [COL_W-1:0]  s3_col;
  logic              s3_last;

  logic              out_free;
  logic [SUM_W-1:0]  adj;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GW_W'(MAX_WIDTH);
      grid_height <= GH_W'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[GH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (grid_width == '0)               w_eff = GW_W'(1);
    else if (grid_width > GW_W'(MAX_WIDTH))      w_eff = GW_W'(MAX_WIDTH);
    else                                         w_eff = grid_width;
    priority if (grid_height == '0)              h_eff = GH_W'(1);
    else if (grid_height > GH_W'(MAX_HEIGHT))    h_eff = GH_W'(MAX_HEIGHT);
    else                                         h_eff = grid_height;
  end

  // raster position
  assign item_fire = item_valid && item_ready;
  assign go        = item_fire && (mode == draining);
  assign col_inc   = {1'b0, col_count} + GW_W'(1);
  assign last_col  = col_inc >= w_eff;
  assign row_inc   = {1'b0, row_count} + (CNT_W + 1)'(1);
  assign frame_end = row_inc >= (CNT_W + 1)'(h_eff);
  assign cur       = draining ? '0 : sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      draining  <= 1'b0;
    end else if (go) begin
      if (last_col) begin
        col_count <= '0;
        if (draining) begin
          draining  <= 1'b0;
          row_count <= '0;
        end else begin
          if (frame_end) begin
            draining <= 1'b1;
          end
          row_count <= row_inc[CNT_W-1:0];
        end
      end else begin
        col_count <= col_inc[COL_W-1:0];
      end
    end
  end

  // column stage
  assign item_ready = !s1_v || s1_commit;
  assign s1_commit  = s1_v && (!s1_res || s2_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (item_ready) begin
      s1_v <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_res   <= row_count != '0;
      s1_cur   <= cur;
      s1_col   <= col_count;
      s1_row   <= ROW_W'(row_count - CNT_W'(1));
      s1_up    <= row_count[CNT_W-1:1] != '0;
      s1_left  <= col_count != '0;
      s1_right <= !last_col;
      s1_last  <= draining && last_col;
    end
    if (s1_commit) begin
      left_q <= mid_c;
    end
  end

  assign lb_ctl.rd_en  = go;
  assign lb_ctl.rd_col = col_count;
  assign lb_ctl.wr_en  = s1_commit;
  assign lb_ctl.wr_col = s1_col;

  fpsa_lines u_lines (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lb_ctl),
    .wr_cur (s1_cur),
    .old_c  (old_c),
    .mid_c  (mid_c),
    .mid_n  (mid_n)
  );

  // cells past the grid edge count as zero
  assign up_m    = s1_up    ? old_c  : '0;
  assign left_m  = s1_left  ? left_q : '0;
  assign right_m = s1_right ? mid_n  : '0;

  // pair sums
  assign s2_free = !s2_v || s3_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_commit && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit && s1_res) begin
      s2_a    <= {up_m[DATA_W-1], up_m} + {left_m[DATA_W-1], left_m};
      s2_b    <= {right_m[DATA_W-1], right_m} + {s1_cur[DATA_W-1], s1_cur};
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_last <= s1_last;
    end
  end

  // full sum
  assign s3_free = !s3_v || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (s3_free) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v && s3_free) begin
      s3_sum  <= {s2_a[PART_W-1], s2_a} + {s2_b[PART_W-1], s2_b};
      s3_row  <= s2_row;
      s3_col  <= s2_col;
      s3_last <= s2_last;
    end
  end

  // divide by four toward zero: bias negative sums by three before the shift
  assign adj      = s3_sum + {{(SUM_W - 2){1'b0}}, s3_sum[SUM_W-1], s3_sum[SUM_W-1]};
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v && out_free) begin
      avg_value  <= adj[DATA_W+1:2];
      out_row    <= s3_row;
      out_col    <= s3_col;
      frame_last <= s3_last;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fpsa_check.sv
// port-level checks for the stencil average block, bound to the top level
`default_nettype none

module fpsa_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_ready,
  input  logic                                result_valid,
  input  logic                                result_ready,
  input  logic signed [fpsa_pkg::DATA_W-1:0]  avg_value,
  input  logic [fpsa_pkg::ROW_W-1:0]          out_row,
  input  logic [fpsa_pkg::COL_W-1:0]          out_col,
  input  logic                                frame_last
);
  import fpsa_pkg::*;

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(avg_value) && $stable(out_row) &&
      $stable(out_col) && $stable(frame_last))
    else $error("result beat changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // with the output free the pipeline must take a new beat
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || result_ready) |-> item_ready)
    else $error("input stalled while output is free");

  a_col_order: assert property (@(posedge clk) disable iff (rst)
    $past(result_valid && result_ready) && result_valid && result_ready &&
      out_row == $past(out_row) && !$past(frame_last) |->
      out_col == $past(out_col) + COL_W'(1))
    else $error("result columns out of order within a row");

endmodule

bind four_point_stencil_average fpsa_check u_fpsa_check (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .avg_value    (avg_value),
  .out_row      (out_row),
  .out_col      (out_col),
  .frame_last   (frame_last)
);

`default_nettype wire

FILE: tb/four_point_stencil_average_tb.sv
// testbench for the four-point stencil average block: raster frames checked against a predictor
`timescale 1ns / 1ps

module four_point_stencil_average_tb;
  import fpsa_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_BEATS   = 280;
  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh80000000;

  typedef struct {
    logic signed [DATA_W-1:0] avg;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     last;
  } cell_result_t;

  class stencil_scoreboard;
    logic signed [DATA_W-1:0] older_line [MAX_WIDTH];
    logic signed [DATA_W-1:0] middle_line [MAX_WIDTH];
    int unsigned  row_idx;
    int unsigned  col_idx;
    bit           in_drain;
    logic [GW_W-1:0] width_reg;
    logic [GH_W-1:0] height_reg;
    cell_result_t pending_cells[$];
    int fail_count;
    int results_seen;
    int samples_taken;
    int ticks_taken;
    int dropped_beats;
    int frames_done;

    function new();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        older_line[i]  = '0;
        middle_line[i] = '0;
      end
      row_idx    = 0;
      col_idx    = 0;
      in_drain   = 1'b0;
      width_reg  = GW_W'(MAX_WIDTH);
      height_reg = GH_W'(MAX_HEIGHT);
      fail_count = 0;
      results_seen = 0;
      samples_taken = 0;
      ticks_taken = 0;
      dropped_beats = 0;
      frames_done = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GRID_WIDTH:  width_reg = data[GW_W-1:0];
        REG_GRID_HEIGHT: height_reg = data[GH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    // accepted beat: dropped if off-phase, else emits the cell one row above and shifts lines
    function void take_beat(logic m, logic signed [DATA_W-1:0] s);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic signed [DATA_W-1:0] down;
      logic signed [SUM_W-1:0] up;
      logic signed [SUM_W-1:0] left;
      logic signed [SUM_W-1:0] right;
      logic signed [SUM_W-1:0] below;
      logic signed [SUM_W-1:0] total;
      logic signed [SUM_W-1:0] quot;
      cell_result_t res;
      w = eff_width();
      h = eff_height();
      if (in_drain != m) begin
        dropped_beats++;
        return;
      end
      if (in_drain) ticks_taken++;
      else samples_taken++;
      down = in_drain ? 32'sd0 : s;
      c = col_idx;
      if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
      if (row_idx >= 1) begin
        r = row_idx - 1;
        up = '0;
        left = '0;
        right = '0;
        if (r >= 1) up = older_line[c];
        if (c >= 1) left = older_line[c-1];
        if (c + 1 < w) right = middle_line[c+1];
        below = down;
        total = up + left + right + below;
        quot = total / 4;
        res.avg  = quot[DATA_W-1:0];
        res.row  = r[ROW_W-1:0];
        res.col  = c[COL_W-1:0];
        res.last = in_drain && (c + 1 >= w);
        pending_cells.push_back(res);
      end
      older_line[c]  = middle_line[c];
      middle_line[c] = down;
      if (c + 1 >= w) begin
        col_idx = 0;
        if (in_drain) begin
          in_drain = 1'b0;
          row_idx = 0;
          frames_done++;
        end else begin
          if (row_idx + 1 >= h) in_drain = 1'b1;
          row_idx++;
        end
      end else begin
        col_idx = c + 1;
      end
    endfunction

    task report(string msg);
      if (fail_count < 40) $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
    endtask

    task check_result(logic signed [DATA_W-1:0] avg, logic [ROW_W-1:0] row,
                      logic [COL_W-1:0] col, logic last);
      cell_result_t want;
      if (pending_cells.size() == 0) begin
        report($sformatf("result for (%0d,%0d) with nothing expected", row, col));
        return;
      end
      want = pending_cells.pop_front();
      results_seen++;
      if (avg !== want.avg)
        report($sformatf("cell (%0d,%0d) avg_value %0d, want %0d",
                         want.row, want.col, avg, want.avg));
      if (row !== want.row)
        report($sformatf("cell (%0d,%0d) out_row %0d", want.row, want.col, row));
      if (col !== want.col)
        report($sformatf("cell (%0d,%0d) out_col %0d", want.row, want.col, col));
      if (last !== want.last)
        report($sformatf("cell (%0d,%0d) frame_last %0b, want %0b",
                         want.row, want.col, last, want.last));
    endtask

    task close_out();
      if (pending_cells.size() != 0)
        report($sformatf("%0d expected cells never came out", pending_cells.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic mode = 1'b0;
  logic signed [DATA_W-1:0] sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [DATA_W-1:0] avg_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic frame_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  stencil_scoreboard sb;

  four_point_stencil_average uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .mode         (mode),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .avg_value    (avg_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .frame_last   (frame_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_result(avg_value, out_row, out_col, frame_last);
  end

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return $signed(DATA_W'($urandom_range(0, 8))) - 32'sd4;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_beat(logic m, logic signed [DATA_W-1:0] s);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    mode       <= m;
    sample     <= s;
    do @(posedge clk); while (!item_ready);
    sb.take_beat(m, s);
  endtask

  // drop valid and let every expected cell and the pipeline tail come out
  task automatic wait_quiet();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame of random samples plus its drain, with a few stray beats mixed in;
  // optionally shrinks the width or changes the height partway through
  task automatic run_frame(bit resize);
    int unsigned sent;
    int unsigned resize_at;
    sent = 0;
    resize_at = resize ? $urandom_range(1, sb.eff_width() * sb.eff_height()) : 0;
    while (!sb.in_drain) begin
      if ($urandom_range(0, 99) < 4) begin
        send_beat(1'b1, pick_sample());
      end else begin
        send_beat(1'b0, pick_sample());
        sent++;
      end
      if (resize_at != 0 && sent == resize_at && !sb.in_drain) begin
        wait_quiet();
        // width never grows mid-frame so no stale line entry is read
        if ($urandom_range(0, 1))
          write_reg(REG_GRID_WIDTH, CFG_DATA_W'($urandom_range(1, sb.eff_width())));
        else
          write_reg(REG_GRID_HEIGHT, CFG_DATA_W'($urandom_range(0, sb.eff_height() + 2)));
        resize_at = 0;
      end
    end
    while (sb.in_drain) begin
      if ($urandom_range(0, 99) < 4) send_beat(1'b0, pick_sample());
      else send_beat(1'b1, pick_sample());
    end
  endtask

  initial begin
    #2_000_000;
    $display("timeout: block stopped making progress");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned start_beats;
    int unsigned w_raw;
    int unsigned h_raw;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: 3x3 checkerboard of extremes with stray beats on both sides
    wait_quiet();
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(3));
    send_beat(1'b1, S_MAX);
    for (int i = 0; i < 9; i++)
      send_beat(1'b0, (i == 4) ? 32'sd0 : ((i % 2) == 0) ? S_MAX : S_MIN);
    send_beat(1'b0, 32'sd7);
    repeat (3) send_beat(1'b1, S_MIN);

    // single-row grid through a zero height; negative sums truncate toward zero
    wait_quiet();
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(0));
    send_beat(1'b0, S_MIN);
    send_beat(1'b0, -32'sd5);
    repeat (2) send_beat(1'b1, 32'sd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      start_beats = sb.samples_taken + sb.ticks_taken;
      while (sb.samples_taken + sb.ticks_taken - start_beats < PHASE_BEATS) begin
        wait_quiet();
        case ($urandom_range(0, 9))
          0: w_raw = 0;
          1: w_raw = 2048 * $urandom_range(1, 3) + $urandom_range(1, 6);
          2: w_raw = $urandom_range(9, 40);
          default: w_raw = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 9))
          0: h_raw = 0;
          1: h_raw = $urandom_range(6, 12);
          default: h_raw = $urandom_range(1, 5);
        endcase
        write_reg(REG_GRID_WIDTH, w_raw[CFG_DATA_W-1:0]);
        write_reg(REG_GRID_HEIGHT, h_raw[CFG_DATA_W-1:0]);
        run_frame($urandom_range(0, 9) == 0);
      end
    end

    wait_quiet();
    sb.close_out();
    $display("ran %0d frames: %0d samples, %0d drain ticks, %0d stray beats dropped",
             sb.frames_done, sb.samples_taken, sb.ticks_taken, sb.dropped_beats);
    $display("checked %0d cells on small random grids under four idle and stall mixes",
             sb.results_seen);
    if (sb.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
